/* hdl/skrt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// skrt_pkg - shared types and constants for the sorted keyed record table
// Field widths, operation and status codes, controller/datapath structs.
// ----------------------------------------------------------------------------
package skrt_pkg;

    localparam int ENTRIES_DEF  = 16;
    localparam int KEY_BITS_DEF = 16;

    localparam int FUNC_W   = 3;
    localparam int KEY_W    = 16;
    localparam int QTY_W    = 32;
    localparam int STATUS_W = 2;

    localparam logic [FUNC_W-1:0] FN_INSERT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_LOOKUP = 3'd1;
    localparam logic [FUNC_W-1:0] FN_UPDATE = 3'd2;
    localparam logic [FUNC_W-1:0] FN_ERASE  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_LIST   = 3'd4;

    localparam logic [QTY_W-1:0] QTY_MAX = 32'h7FFF_FFFF;
    localparam logic [QTY_W-1:0] QTY_MIN = 32'h8000_0000;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_DUP  = 2'd2,
        ST_FULL = 2'd3
    } status_t;

    // Which result word the datapath builds
    typedef enum logic [2:0] {
        RES_FULL  = 3'd0,
        RES_DUP   = 3'd1,
        RES_NEW   = 3'd2,
        RES_HIT   = 3'd3,
        RES_MISS  = 3'd4,
        RES_SUM   = 3'd5,
        RES_EMPTY = 3'd6,
        RES_REC   = 3'd7
    } res_sel_t;

    typedef struct packed {
        logic     load;
        logic     scan_step;
        logic     emit;
        res_sel_t res_sel;
        logic     write_sum;
        logic     shup_init;
        logic     shup_step;
        logic     write_new;
        logic     shdn_init;
        logic     shdn_step;
        logic     dec_count;
        logic     list_read;
        logic     list_next;
    } cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              cnt_zero;
        logic              cnt_full;
        logic              pos_at_count;
        logic              rd_pend;
        logic              key_less;
        logic              hit;
        logic              idx_at_pos;
        logic              idx_at_count;
        logic              mv_pend;
        logic              list_last;
        logic              out_free;
    } sts_t;

endpackage
`default_nettype wire

/* hdl/skrt_req_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// skrt_req_if - request channel of the record table
// One word per operation: function code, key and amount.
// ----------------------------------------------------------------------------
interface skrt_req_if;
    import skrt_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic [KEY_W-1:0]         key;
    logic signed [QTY_W-1:0]  amount;

    modport source (output valid, func, key, amount, input ready);
    modport sink   (input valid, func, key, amount, output ready);
endinterface
`default_nettype wire

/* hdl/skrt_rsp_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// skrt_rsp_if - response channel of the record table
// One word per result: status, key, quantity and last flag.
// ----------------------------------------------------------------------------
interface skrt_rsp_if;
    import skrt_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic [KEY_W-1:0]         found_key;
    logic signed [QTY_W-1:0]  quantity;
    logic                     last;

    modport source (output valid, status, found_key, quantity, last, input ready);
    modport sink   (input valid, status, found_key, quantity, last, output ready);
endinterface
`default_nettype wire

/* hdl/skrt_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// skrt_ram - generic single-write, single-read RAM
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
module skrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

/* hdl/skrt_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// skrt_ctrl - operation sequencer of the record table
// Steps scan, decision, shift and list phases; issues datapath commands.
// ----------------------------------------------------------------------------
module skrt_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire skrt_pkg::sts_t sts,
    output skrt_pkg::cmd_t      cmd
);
    import skrt_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_SCAN     = 7'b0000010,
        S_DECIDE   = 7'b0000100,
        S_SHUP     = 7'b0001000,
        S_SHDN     = 7'b0010000,
        S_LIST_RD  = 7'b0100000,
        S_LIST_OUT = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (sts.func == FN_LIST)
                begin
                    state_next = S_LIST_RD;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                    // stop at the first record whose key is not below the target
                    if (sts.pos_at_count || (sts.rd_pend && !sts.key_less))
                    begin
                        state_next = S_DECIDE;
                    end
                end
            end
            S_DECIDE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                    case (sts.func)
                        FN_INSERT:
                        begin
                            if (sts.cnt_full)
                            begin
                                cmd.res_sel = RES_FULL;
                            end
                            else if (sts.hit)
                            begin
                                cmd.res_sel = RES_DUP;
                            end
                            else
                            begin
                                cmd.res_sel   = RES_NEW;
                                cmd.shup_init = 1'b1;
                                state_next    = S_SHUP;
                            end
                        end
                        FN_LOOKUP:
                        begin
                            cmd.res_sel = sts.hit ? RES_HIT : RES_MISS;
                        end
                        FN_UPDATE:
                        begin
                            cmd.res_sel   = sts.hit ? RES_SUM : RES_MISS;
                            cmd.write_sum = sts.hit;
                        end
                        FN_ERASE:
                        begin
                            if (sts.hit)
                            begin
                                cmd.res_sel   = RES_HIT;
                                cmd.shdn_init = 1'b1;
                                state_next    = S_SHDN;
                            end
                            else
                            begin
                                cmd.res_sel = RES_MISS;
                            end
                        end
                        FN_LIST:
                        begin
                            cmd.res_sel = RES_EMPTY;
                        end
                        default:
                        begin
                            cmd.res_sel = RES_MISS;
                        end
                    endcase
                end
            end
            S_SHUP:
            begin
                if (sts.idx_at_pos && !sts.mv_pend)
                begin
                    cmd.write_new = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    cmd.shup_step = 1'b1;
                end
            end
            S_SHDN:
            begin
                if (sts.idx_at_count && !sts.mv_pend)
                begin
                    cmd.dec_count = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    cmd.shdn_step = 1'b1;
                end
            end
            S_LIST_RD:
            begin
                if (sts.cnt_zero)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    cmd.list_read = 1'b1;
                    state_next    = S_LIST_OUT;
                end
            end
            S_LIST_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.res_sel   = RES_REC;
                    cmd.list_next = 1'b1;
                    state_next    = sts.list_last ? S_IDLE : S_LIST_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

`ifndef SYNTH
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != S_IDLE))
        else $error("accepted word did not start an operation");

    a_emit_phase: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (state_reg == S_DECIDE || state_reg == S_LIST_OUT))
        else $error("result issued outside decision or list phase");

    a_new_after_moves: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_new |-> (!sts.mv_pend && sts.idx_at_pos))
        else $error("new record written before shift completed");
`endif

endmodule
`default_nettype wire

/* hdl/skrt_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// skrt_datapath - record store, pointers and result register
// Holds the sorted record RAM, scan and shift pointers, and the output word.
// ----------------------------------------------------------------------------
module skrt_datapath #(
    parameter int ENTRIES  = skrt_pkg::ENTRIES_DEF,
    parameter int KEY_BITS = skrt_pkg::KEY_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire skrt_pkg::cmd_t                      cmd,
    output skrt_pkg::sts_t                           sts,
    input  wire logic [skrt_pkg::FUNC_W-1:0]         func,
    input  wire logic [skrt_pkg::KEY_W-1:0]          key,
    input  wire logic signed [skrt_pkg::QTY_W-1:0]   amount,
    skrt_rsp_if.source                               rsp
);
    import skrt_pkg::*;

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int DW = KEY_BITS + QTY_W;

    logic [FUNC_W-1:0]   func_reg,   func_next;
    logic [KEY_BITS-1:0] key_reg,    key_next;
    logic [QTY_W-1:0]    amount_reg, amount_next;
    logic [CW-1:0]       count_reg,  count_next;
    logic [CW-1:0]       idx_reg,    idx_next;
    logic [CW-1:0]       pos_reg,    pos_next;
    logic [AW-1:0]       wdst_reg,   wdst_next;
    logic                rd_pend_reg, rd_pend_next;
    logic                mv_pend_reg, mv_pend_next;
    logic                hit_reg,    hit_next;
    logic [QTY_W-1:0]    hitq_reg,   hitq_next;

    logic                out_valid_reg,  out_valid_next;
    status_t             out_status_reg, out_status_next;
    logic [KEY_W-1:0]    out_key_reg,    out_key_next;
    logic [QTY_W-1:0]    out_qty_reg,    out_qty_next;
    logic                out_last_reg,   out_last_next;

    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [DW-1:0] ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic [DW-1:0] rd_data;

    logic [KEY_BITS-1:0] rd_key;
    logic [QTY_W-1:0]    rd_qty;
    logic                key_less;
    logic                key_eq;
    logic [QTY_W:0]      sum_wide;
    logic [QTY_W-1:0]    sum_sat;
    logic [CW-1:0]       idx_inc;
    logic [CW-1:0]       idx_dec;
    logic                out_free;
    logic                list_last;

    skrt_ram #(
        .WIDTH (DW),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (rd_data)
    );

    assign rd_key   = rd_data[DW-1 -: KEY_BITS];
    assign rd_qty   = rd_data[QTY_W-1:0];
    assign key_less = (rd_key < key_reg);
    assign key_eq   = (rd_key == key_reg);
    assign idx_inc  = idx_reg + 1'b1;
    assign idx_dec  = idx_reg - 1'b1;
    assign out_free = !out_valid_reg || rsp.ready;
    assign list_last = (idx_inc == count_reg);

    // saturate on signed overflow of the 32-bit sum
    assign sum_wide = {hitq_reg[QTY_W-1], hitq_reg} + {amount_reg[QTY_W-1], amount_reg};
    assign sum_sat  = (sum_wide[QTY_W] != sum_wide[QTY_W-1])
                    ? (sum_wide[QTY_W] ? QTY_MIN : QTY_MAX)
                    : sum_wide[QTY_W-1:0];

    always_comb
    begin
        func_next       = func_reg;
        key_next        = key_reg;
        amount_next     = amount_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        wdst_next       = wdst_reg;
        rd_pend_next    = rd_pend_reg;
        mv_pend_next    = mv_pend_reg;
        hit_next        = hit_reg;
        hitq_next       = hitq_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_key_next    = out_key_reg;
        out_qty_next    = out_qty_reg;
        out_last_next   = out_last_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = wdst_reg;
        ram_wr_data     = rd_data;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = idx_reg[AW-1:0];

        if (cmd.load)
        begin
            func_next    = func;
            key_next     = KEY_BITS'(key);
            amount_next  = amount;
            idx_next     = '0;
            pos_next     = '0;
            rd_pend_next = 1'b0;
            hit_next     = 1'b0;
        end

        // read one record ahead, compare the one read last cycle
        if (cmd.scan_step)
        begin
            ram_rd_en    = (idx_reg < count_reg);
            rd_pend_next = (idx_reg < count_reg);
            if (idx_reg < count_reg)
            begin
                idx_next = idx_inc;
            end
            if (rd_pend_reg)
            begin
                if (key_less)
                begin
                    pos_next = pos_reg + 1'b1;
                end
                else
                begin
                    hit_next  = key_eq;
                    hitq_next = rd_qty;
                end
            end
        end

        if (cmd.write_sum)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pos_reg[AW-1:0];
            ram_wr_data = {key_reg, sum_sat};
        end

        if (cmd.shup_init)
        begin
            idx_next     = count_reg;
            mv_pend_next = 1'b0;
        end

        // move records up by one, top first
        if (cmd.shup_step)
        begin
            if (mv_pend_reg)
            begin
                ram_wr_en = 1'b1;
            end
            if (idx_reg != pos_reg)
            begin
                ram_rd_en    = 1'b1;
                ram_rd_addr  = idx_dec[AW-1:0];
                wdst_next    = idx_reg[AW-1:0];
                idx_next     = idx_dec;
                mv_pend_next = 1'b1;
            end
            else
            begin
                mv_pend_next = 1'b0;
            end
        end

        if (cmd.write_new)
        begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pos_reg[AW-1:0];
            ram_wr_data = {key_reg, amount_reg};
            count_next  = count_reg + 1'b1;
        end

        if (cmd.shdn_init)
        begin
            idx_next     = pos_reg + 1'b1;
            mv_pend_next = 1'b0;
        end

        // move records down by one, bottom first
        if (cmd.shdn_step)
        begin
            if (mv_pend_reg)
            begin
                ram_wr_en = 1'b1;
            end
            if (idx_reg != count_reg)
            begin
                ram_rd_en    = 1'b1;
                ram_rd_addr  = idx_reg[AW-1:0];
                wdst_next    = idx_dec[AW-1:0];
                idx_next     = idx_inc;
                mv_pend_next = 1'b1;
            end
            else
            begin
                mv_pend_next = 1'b0;
            end
        end

        if (cmd.dec_count)
        begin
            count_next = count_reg - 1'b1;
        end

        if (cmd.list_read)
        begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = idx_reg[AW-1:0];
        end

        if (cmd.list_next)
        begin
            idx_next = idx_inc;
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            out_key_next   = KEY_W'(key_reg);
            out_last_next  = 1'b1;
            case (cmd.res_sel)
                RES_FULL:
                begin
                    out_status_next = ST_FULL;
                    out_qty_next    = '0;
                end
                RES_DUP:
                begin
                    out_status_next = ST_DUP;
                    out_qty_next    = hitq_reg;
                end
                RES_NEW:
                begin
                    out_status_next = ST_OK;
                    out_qty_next    = amount_reg;
                end
                RES_HIT:
                begin
                    out_status_next = ST_OK;
                    out_qty_next    = hitq_reg;
                end
                RES_SUM:
                begin
                    out_status_next = ST_OK;
                    out_qty_next    = sum_sat;
                end
                RES_EMPTY:
                begin
                    out_status_next = ST_MISS;
                    out_key_next    = '0;
                    out_qty_next    = '0;
                end
                RES_REC:
                begin
                    out_status_next = ST_OK;
                    out_key_next    = KEY_W'(rd_key);
                    out_qty_next    = rd_qty;
                    out_last_next   = list_last;
                end
                default:
                begin
                    out_status_next = ST_MISS;
                    out_qty_next    = '0;
                end
            endcase
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_pend_reg   <= 1'b0;
            mv_pend_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            func_reg      <= FN_INSERT;
            idx_reg       <= '0;
            pos_reg       <= '0;
        end
        else
        begin
            count_reg     <= count_next;
            rd_pend_reg   <= rd_pend_next;
            mv_pend_reg   <= mv_pend_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
            func_reg      <= func_next;
            idx_reg       <= idx_next;
            pos_reg       <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        amount_reg     <= amount_next;
        wdst_reg       <= wdst_next;
        hitq_reg       <= hitq_next;
        out_status_reg <= out_status_next;
        out_key_reg    <= out_key_next;
        out_qty_reg    <= out_qty_next;
        out_last_reg   <= out_last_next;
    end

    assign sts.func         = func_reg;
    assign sts.cnt_zero     = (count_reg == '0);
    assign sts.cnt_full     = (count_reg >= CW'(ENTRIES));
    assign sts.pos_at_count = (pos_reg == count_reg);
    assign sts.rd_pend      = rd_pend_reg;
    assign sts.key_less     = key_less;
    assign sts.hit          = hit_reg;
    assign sts.idx_at_pos   = (idx_reg == pos_reg);
    assign sts.idx_at_count = (idx_reg == count_reg);
    assign sts.mv_pend      = mv_pend_reg;
    assign sts.list_last    = list_last;
    assign sts.out_free     = out_free;

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.found_key = out_key_reg;
    assign rsp.quantity  = out_qty_reg;
    assign rsp.last      = out_last_reg;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(ENTRIES))
        else $error("record count beyond table size");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free)
        else $error("result overwrote a word not yet taken");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write_new |=> (count_reg == CW'($past(count_reg) + 1'b1)))
        else $error("insert did not grow the record count");
`endif

endmodule
`default_nettype wire

/* hdl/sorted_keyed_record_table.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_keyed_record_table - sorted key/quantity table with list output
// Insert, lookup, saturating update, erase and ordered listing of records.
// ----------------------------------------------------------------------------
//  channel  dir  word                               handshake
//  req      in   func, key, amount                  valid/ready
//  rsp      out  status, found_key, quantity, last  valid/ready
//
//  The scan reads the sorted RAM one record per cycle. Insert then moves the
//  records at and above the position up, and erase those above it down, one per
//  cycle; list reads each record and then emits it on the single read port.
//  Reset clears the count, pointers and flags; RAM contents are not cleared.
//  A waiting result sits in the output register; the next word is taken
//  while it waits, and the datapath holds whenever a new result finds it full.
// ----------------------------------------------------------------------------
module sorted_keyed_record_table #(
    parameter int ENTRIES  = skrt_pkg::ENTRIES_DEF,
    parameter int KEY_BITS = skrt_pkg::KEY_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    skrt_req_if.sink   req,
    skrt_rsp_if.source rsp
);
    import skrt_pkg::*;

    cmd_t cmd;
    sts_t sts;

    skrt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    skrt_datapath #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .sts    (sts),
        .func   (req.func),
        .key    (req.key),
        .amount (req.amount),
        .rsp    (rsp)
    );

endmodule
`default_nettype wire
